[sv/text_mode_console_writer_defines.svh]
// Assertion macros shared by the console writer checker.
// No dependencies; assumes clk and rst_n are visible at the point of use.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// antecedent true now -> consequent true in the same cycle
`define TMCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent true now -> consequent true in the next cycle
`define TMCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tmcw_pkg.sv]
// Shared types, codes and microcode ROM for the text console writer.
// No dependencies.
package tmcw_pkg;

  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_GOTO   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_SCROLL = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  // microprogram step addresses
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUT   = 4'd1;
  localparam logic [3:0] S_SCR   = 4'd2;
  localparam logic [3:0] S_SCRZ  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_GOTO  = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_READ  = 4'd10;
  localparam logic [3:0] S_LATCH = 4'd11;
  localparam logic [3:0] S_BOOT  = 4'd12;
  localparam logic [3:0] S_BFILL = 4'd13;
  localparam logic [3:0] S_BEND  = 4'd14;

  typedef enum logic [3:0] {
    A_NONE  = 4'd0,
    A_PUT   = 4'd1,
    A_MUL   = 4'd2,
    A_SHIFT = 4'd3,
    A_COPY  = 4'd4,
    A_FILL  = 4'd5,
    A_FIN   = 4'd6,
    A_GOTO  = 4'd7,
    A_CLR   = 4'd8,
    A_READ  = 4'd9,
    A_LATCH = 4'd10
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_DISPATCH  = 3'd2,
    C_NOWRAP    = 3'd3,
    C_BIG       = 3'd4,
    C_ZERO      = 3'd5,
    C_SRC_MORE  = 3'd6,
    C_FILL_MORE = 3'd7
  } cond_t;

  typedef struct packed {
    act_t       act;
    cond_t      cond;
    logic [3:0] target;
  } uword_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] lines;
    logic [10:0] addr;
  } cmd_t;

  typedef struct packed {
    logic nowrap;
    logic big;
    logic zero;
    logic src_more;
    logic fill_more;
  } stat_t;

  function automatic uword_t urom(input logic [3:0] step);
    uword_t w;
    unique case (step)
      S_IDLE:  w = '{A_NONE,  C_DISPATCH,  S_IDLE};
      S_PUT:   w = '{A_PUT,   C_NOWRAP,    S_FIN};
      S_SCR:   w = '{A_NONE,  C_BIG,       S_CLR};
      S_SCRZ:  w = '{A_MUL,   C_ZERO,      S_FIN};
      S_SHIFT: w = '{A_SHIFT, C_NEVER,     S_IDLE};
      S_COPY:  w = '{A_COPY,  C_SRC_MORE,  S_COPY};
      S_FILL:  w = '{A_FILL,  C_FILL_MORE, S_FILL};
      S_FIN:   w = '{A_FIN,   C_ALWAYS,    S_IDLE};
      S_GOTO:  w = '{A_GOTO,  C_ALWAYS,    S_FIN};
      S_CLR:   w = '{A_CLR,   C_ALWAYS,    S_FILL};
      S_READ:  w = '{A_READ,  C_NEVER,     S_IDLE};
      S_LATCH: w = '{A_LATCH, C_ALWAYS,    S_FIN};
      S_BOOT:  w = '{A_CLR,   C_NEVER,     S_IDLE};
      S_BFILL: w = '{A_FILL,  C_FILL_MORE, S_BFILL};
      S_BEND:  w = '{A_NONE,  C_ALWAYS,    S_IDLE};
      default: w = '{A_NONE,  C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] dispatch(input logic [2:0] op);
    logic [3:0] s;
    unique case (op)
      OP_PUT:    s = S_PUT;
      OP_GOTO:   s = S_GOTO;
      OP_CLEAR:  s = S_CLR;
      OP_SCROLL: s = S_SCR;
      OP_READ:   s = S_READ;
      default:   s = S_FIN;
    endcase
    return s;
  endfunction

endpackage

[sv/tmcw_seq.sv]
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on tmcw_pkg.
module tmcw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0]       opcode,
  input  tmcw_pkg::stat_t  stat,
  output tmcw_pkg::act_t   act,
  output logic             busy
);

  logic [3:0]       step_r, step_nxt;
  logic [3:0]       step_inc;
  tmcw_pkg::uword_t uw;
  logic             take;

  assign uw       = tmcw_pkg::urom(step_r);
  assign step_inc = 4'(step_r + 4'd1);
  assign act      = uw.act;
  assign busy     = (step_r != tmcw_pkg::S_IDLE);

  always_comb begin
    take     = 1'b0;
    step_nxt = step_inc;
    unique case (uw.cond)
      tmcw_pkg::C_NEVER:     take = 1'b0;
      tmcw_pkg::C_ALWAYS:    take = 1'b1;
      tmcw_pkg::C_NOWRAP:    take = stat.nowrap;
      tmcw_pkg::C_BIG:       take = stat.big;
      tmcw_pkg::C_ZERO:      take = stat.zero;
      tmcw_pkg::C_SRC_MORE:  take = stat.src_more;
      tmcw_pkg::C_FILL_MORE: take = stat.fill_more;
      tmcw_pkg::C_DISPATCH:  take = 1'b0;
      default:               take = 1'b0;
    endcase
    if (uw.cond == tmcw_pkg::C_DISPATCH) begin
      step_nxt = start ? tmcw_pkg::dispatch(opcode) : step_r;
    end else if (take) begin
      step_nxt = uw.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tmcw_pkg::S_BOOT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[sv/tmcw_dp.sv]
// Datapath: command register, cursors, sweep pointers and the cell store.
// Depends on tmcw_pkg; driven by tmcw_seq actions.
module tmcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  tmcw_pkg::cmd_t  cmd,
  input  logic [7:0]      attr,
  input  tmcw_pkg::act_t  act,
  output tmcw_pkg::stat_t stat,
  output logic [10:0]     write_position,
  output logic [10:0]     shown_cursor,
  output logic [15:0]     cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [15:0] mem [CELLS];

  tmcw_pkg::cmd_t cmd_r;
  logic [7:0]     lines_r, lines_nxt;
  logic [CW-1:0]  cur_r, cur_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [CW-1:0]  shown_r, shown_nxt;
  logic [CW-1:0]  shift_r, shift_nxt;
  logic [CW-1:0]  src_r, src_nxt;
  logic [CW-1:0]  dst_r, dst_nxt;
  logic           rdv_r, rdv_nxt;
  logic           look_r, look_nxt;
  logic [15:0]    q_r;
  logic [15:0]    data_r, data_nxt;

  logic           nl;
  logic           we;
  logic [AW-1:0]  wa, ra;
  logic [15:0]    wd;
  logic [CLW-1:0] col_sat;
  logic [RW-1:0]  row_sat;

  assign nl = (cmd_r.ch == tmcw_pkg::NEWLINE_CODE);

  assign stat.nowrap    = nl ? (cur_r < CW'(CELLS - COLUMNS)) : (cur_r != CW'(CELLS - 1));
  assign stat.big       = (int'(lines_r) > ROWS);
  assign stat.zero      = (lines_r == 8'd0);
  assign stat.src_more  = (src_r != CW'(CELLS));
  assign stat.fill_more = (dst_r != CW'(CELLS - 1));

  assign col_sat = (int'(cmd_r.col) >= COLUMNS) ? CLW'(COLUMNS - 1) : CLW'(cmd_r.col);
  assign row_sat = (int'(cmd_r.row) >= ROWS) ? RW'(ROWS - 1) : RW'(cmd_r.row);

  assign ra = (act == tmcw_pkg::A_READ) ? AW'(cmd_r.addr) : src_r[AW-1:0];

  // store write port: copy write-back has priority over the program's writes
  always_comb begin
    we = 1'b0;
    wa = cur_r[AW-1:0];
    wd = 16'd0;
    priority if (rdv_r) begin
      we = 1'b1;
      wa = dst_r[AW-1:0];
      wd = q_r;
    end else if (act == tmcw_pkg::A_PUT && !nl) begin
      we = 1'b1;
      wa = cur_r[AW-1:0];
      wd = {attr, cmd_r.ch};
    end else if (act == tmcw_pkg::A_FILL) begin
      we = 1'b1;
      wa = dst_r[AW-1:0];
      wd = 16'd0;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    priority if (rdv_r || act == tmcw_pkg::A_FILL) begin
      dst_nxt = CW'(dst_r + CW'(1));
    end else if (act == tmcw_pkg::A_SHIFT || act == tmcw_pkg::A_CLR) begin
      dst_nxt = '0;
    end else begin
      dst_nxt = dst_r;
    end
  end

  always_comb begin
    lines_nxt = lines_r;
    cur_nxt   = cur_r;
    col_nxt   = col_r;
    shown_nxt = shown_r;
    shift_nxt = shift_r;
    src_nxt   = src_r;
    rdv_nxt   = 1'b0;
    look_nxt  = look_r;
    data_nxt  = data_r;
    unique case (act)
      tmcw_pkg::A_PUT: begin
        lines_nxt = 8'd1;
        if (nl) begin
          cur_nxt = CW'(cur_r + CW'(COLUMNS) - CW'(col_r));
          col_nxt = '0;
        end else begin
          cur_nxt = CW'(cur_r + CW'(1));
          col_nxt = (int'(col_r) == COLUMNS - 1) ? '0 : CLW'(col_r + CLW'(1));
        end
      end
      tmcw_pkg::A_MUL: shift_nxt = CW'(CW'(lines_r) * CW'(COLUMNS));
      tmcw_pkg::A_SHIFT: begin
        src_nxt = shift_r;
        if (cur_r < shift_r) begin
          cur_nxt = '0;
          col_nxt = '0;
        end else begin
          cur_nxt = CW'(cur_r - shift_r);
        end
      end
      tmcw_pkg::A_COPY: begin
        if (stat.src_more) begin
          src_nxt = CW'(src_r + CW'(1));
          rdv_nxt = 1'b1;
        end
      end
      tmcw_pkg::A_FIN: begin
        if (cmd_r.op == tmcw_pkg::OP_PUT && !nl) shown_nxt = cur_r;
      end
      tmcw_pkg::A_GOTO: begin
        cur_nxt   = CW'(CW'(row_sat) * CW'(COLUMNS)) + CW'(col_sat);
        shown_nxt = CW'(CW'(row_sat) * CW'(COLUMNS)) + CW'(col_sat);
        col_nxt   = col_sat;
      end
      tmcw_pkg::A_CLR: begin
        cur_nxt   = '0;
        col_nxt   = '0;
        shown_nxt = '0;
      end
      tmcw_pkg::A_READ:  look_nxt = (int'(cmd_r.addr) < CELLS);
      tmcw_pkg::A_LATCH: data_nxt = look_r ? q_r : 16'd0;
      tmcw_pkg::A_FILL, tmcw_pkg::A_NONE: ;
      default: ;
    endcase
    if (accept) begin
      lines_nxt = cmd.lines;
      data_nxt  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    q_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_r <= cmd;
    lines_r <= lines_nxt;
    shift_r <= shift_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      col_r   <= '0;
      shown_r <= '0;
      rdv_r   <= 1'b0;
      look_r  <= 1'b0;
      data_r  <= 16'd0;
    end else begin
      cur_r   <= cur_nxt;
      col_r   <= col_nxt;
      shown_r <= shown_nxt;
      rdv_r   <= rdv_nxt;
      look_r  <= look_nxt;
      data_r  <= data_nxt;
    end
  end

  assign write_position = 11'(cur_r);
  assign shown_cursor   = 11'(shown_r);
  assign cell_data      = data_r;

endmodule

[sv/text_mode_console_writer.sv]
// Text console writer: COLUMNS x ROWS grid of 16-bit cells (attribute:char).
// Commands: put char, goto, clear, scroll up by N rows, read cell.
// Channels: a command is taken at a clock edge with start high and busy low;
// in_opcode selects the command, the other in_ fields are its operands.
// Each command gives one result, shown for one cycle with out_strobe high:
// out_write_position, out_shown_cursor and out_cell_data (read cell only).
// The receiver cannot stall; the result sits in registers and a new command
// is accepted in the same cycle the strobe is high.
// Command sequences: put char (no scroll), goto, read cell and an unknown opcode
//   touch no more than one cell; clear sweeps the whole store; scroll by n
//   (1..ROWS) copies the store up n rows and blanks the rest; scroll by 0 leaves
//   it alone; by more than ROWS it clears; a wrapping put also scrolls by one row.
// The store has one write and one read port; scroll and clear walk it one
// cell per cycle, and the microprogram sets the per-command step count.
// cfg_attribute_byte is written whenever cfg_valid is high (cfg_ready is
// always high) and applies to cells written by later put char commands.
// Reset: synchronous, rst_n low. After it, busy stays high while the store
// is swept to zero; the attribute returns to 0x07 and both cursors to 0.
module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_row,
  input  logic [7:0]  in_scroll_lines,
  input  logic [10:0] in_cell_address,
  output logic        out_strobe,
  output logic [10:0] out_write_position,
  output logic [10:0] out_shown_cursor,
  output logic [15:0] out_cell_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_attribute_byte
);

  tmcw_pkg::act_t  act;
  tmcw_pkg::stat_t stat;
  tmcw_pkg::cmd_t  cmd;
  logic            accept;
  logic [7:0]      attr_r;
  logic            strobe_r;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cmd       = '{in_opcode, in_char_code, in_column, in_row,
                       in_scroll_lines, in_cell_address};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r   <= tmcw_pkg::ATTR_RESET;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) attr_r <= cfg_attribute_byte;
      strobe_r <= (act == tmcw_pkg::A_FIN);
    end
  end

  assign out_strobe = strobe_r;

  tmcw_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .stat   (stat),
    .act    (act),
    .busy   (busy)
  );

  tmcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .cmd            (cmd),
    .attr           (attr_r),
    .act            (act),
    .stat           (stat),
    .write_position (out_write_position),
    .shown_cursor   (out_shown_cursor),
    .cell_data      (out_cell_data)
  );

endmodule

[sv/tmcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_mode_console_writer_defines.svh.
`include "text_mode_console_writer_defines.svh"

module tmcw_checker #(
  parameter int CELLS = 2000
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [10:0] out_write_position,
  input logic [10:0] out_shown_cursor
);

  `TMCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after command transfer")
  `TMCW_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result strobe while busy")
  `TMCW_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held")
  `TMCW_ASSERT_NOW(a_cursor_range, out_strobe && CELLS < 2048,
                   int'(out_write_position) < CELLS && int'(out_shown_cursor) < CELLS,
                   "cursor beyond last cell")

endmodule

bind text_mode_console_writer tmcw_checker #(
  .CELLS (COLUMNS * ROWS)
) u_tmcw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_write_position (out_write_position),
  .out_shown_cursor   (out_shown_cursor)
);

[tb/console_checker.sv]
`timescale 1ns / 100ps
// Checker for the text console writer: keeps its own copy of the cell store and cursors,
// predicts each command's result and compares it field by field with the result strobe.
// Depends on tmcw_pkg for the opcode, newline and attribute reset codes.
module console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_row,
  input  logic [7:0]  in_scroll_lines,
  input  logic [10:0] in_cell_address,
  input  logic        out_strobe,
  input  logic [10:0] out_write_position,
  input  logic [10:0] out_shown_cursor,
  input  logic [15:0] out_cell_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_attribute_byte,
  output int          errors,
  output int          pending
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [10:0] write_position;
    logic [10:0] shown_cursor;
    logic [15:0] cell_data;
  } console_report_t;

  logic [15:0]     cells [CELLS];
  int unsigned     text_pos;
  int unsigned     shown_pos;
  logic [7:0]      attr;
  console_report_t awaited_reports [$];
  int              error_tally = 0;

  function automatic void blank_screen();
    foreach (cells[i]) cells[i] = 16'h0000;
    text_pos  = 0;
    shown_pos = 0;
  endfunction

  function automatic void scroll_up(int unsigned lines);
    int unsigned shift;
    int unsigned i;
    if (lines > ROWS) begin
      blank_screen();
      return;
    end
    shift = lines * COLUMNS;
    for (i = 0; i < CELLS; i++)
      cells[i] = (i + shift < CELLS) ? cells[i + shift] : 16'h0000;
    text_pos = (text_pos < shift) ? 0 : text_pos - shift;
  endfunction

  function automatic console_report_t run_command(
      logic [2:0] op, logic [7:0] ch, logic [6:0] col, logic [4:0] row,
      logic [7:0] lines, logic [10:0] addr);
    console_report_t r;
    int unsigned c;
    int unsigned rw;
    r.cell_data = 16'h0000;
    case (op)
      tmcw_pkg::OP_PUT: begin
        if (ch == tmcw_pkg::NEWLINE_CODE) begin
          // newline leaves the shown cursor alone
          text_pos = text_pos + COLUMNS - text_pos % COLUMNS;
          if (text_pos >= CELLS) scroll_up(1);
        end else begin
          if (text_pos < CELLS) cells[text_pos] = {attr, ch};
          text_pos++;
          if (text_pos >= CELLS) scroll_up(1);
          shown_pos = text_pos;
        end
      end
      tmcw_pkg::OP_GOTO: begin
        c  = (col >= COLUMNS) ? COLUMNS - 1 : col;
        rw = (row >= ROWS) ? ROWS - 1 : row;
        text_pos  = rw * COLUMNS + c;
        shown_pos = text_pos;
      end
      tmcw_pkg::OP_CLEAR:  blank_screen();
      tmcw_pkg::OP_SCROLL: scroll_up(lines);
      tmcw_pkg::OP_READ: begin
        if (addr < CELLS) r.cell_data = cells[addr];
      end
      default: ;
    endcase
    r.write_position = text_pos[10:0];
    r.shown_cursor   = shown_pos[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    console_report_t want;
    if (!rst_n) begin
      blank_screen();
      attr = tmcw_pkg::ATTR_RESET;
      awaited_reports.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t console_checker: unexpected result, expected none, got pos %0d",
                   $time, out_write_position);
          error_tally++;
        end else begin
          want = awaited_reports.pop_front();
          if (out_write_position !== want.write_position) begin
            $display("%0t console_checker: write_position expected %0d got %0d",
                     $time, want.write_position, out_write_position);
            error_tally++;
          end
          if (out_shown_cursor !== want.shown_cursor) begin
            $display("%0t console_checker: shown_cursor expected %0d got %0d",
                     $time, want.shown_cursor, out_shown_cursor);
            error_tally++;
          end
          if (out_cell_data !== want.cell_data) begin
            $display("%0t console_checker: cell_data expected %h got %h",
                     $time, want.cell_data, out_cell_data);
            error_tally++;
          end
        end
      end
      if (cfg_valid && cfg_ready) attr = cfg_attribute_byte;
      if (start && !busy)
        awaited_reports.push_back(run_command(in_opcode, in_char_code, in_column, in_row,
                                              in_scroll_lines, in_cell_address));
    end
    errors  <= error_tally;
    pending <= awaited_reports.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the text console writer testbench: clock, reset, command and attribute stimulus,
// stall watchdog and verdict. Depends on tmcw_pkg, the block and console_checker.
module tb_top;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int STALL_LIMIT = 10000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 230;
  localparam logic [2:0] OP_HIGHEST = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [7:0]  in_char_code;
  logic [6:0]  in_column;
  logic [4:0]  in_row;
  logic [7:0]  in_scroll_lines;
  logic [10:0] in_cell_address;
  logic        out_strobe;
  logic [10:0] out_write_position;
  logic [10:0] out_shown_cursor;
  logic [15:0] out_cell_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_attribute_byte;
  int          errors;
  int          pending;
  int          stall_cycles;
  logic [10:0] last_pos;

  text_mode_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_char_code(in_char_code), .in_column(in_column),
    .in_row(in_row), .in_scroll_lines(in_scroll_lines), .in_cell_address(in_cell_address),
    .out_strobe(out_strobe), .out_write_position(out_write_position),
    .out_shown_cursor(out_shown_cursor), .out_cell_data(out_cell_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_attribute_byte(cfg_attribute_byte)
  );

  console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_char_code(in_char_code), .in_column(in_column),
    .in_row(in_row), .in_scroll_lines(in_scroll_lines), .in_cell_address(in_cell_address),
    .out_strobe(out_strobe), .out_write_position(out_write_position),
    .out_shown_cursor(out_shown_cursor), .out_cell_data(out_cell_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_attribute_byte(cfg_attribute_byte),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reset clear sweep and scroll walks make no transfer while they walk the store
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) last_pos <= '0;
    else if (out_strobe) last_pos <= out_write_position;
  end

  task automatic issue(input logic [2:0] op, input logic [7:0] ch, input logic [6:0] col,
                       input logic [4:0] row, input logic [7:0] lines,
                       input logic [10:0] addr);
    start           <= 1'b1;
    in_opcode       <= op;
    in_char_code    <= ch;
    in_column       <= col;
    in_row          <= row;
    in_scroll_lines <= lines;
    in_cell_address <= addr;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic write_attr(input logic [7:0] value);
    drain();
    cfg_valid          <= 1'b1;
    cfg_attribute_byte <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          p;
    int          n;
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  ch;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  lines;
    logic [10:0] addr;
    logic [7:0]  phase_attr [PHASES];

    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_opcode          <= tmcw_pkg::OP_PUT;
    in_char_code       <= '0;
    in_column          <= '0;
    in_row             <= '0;
    in_scroll_lines    <= '0;
    in_cell_address    <= '0;
    cfg_valid          <= 1'b0;
    cfg_attribute_byte <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, wrap at the last cell, newline on the last row, scroll edges
    issue(tmcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'd0,         11'd1999);
    issue(tmcw_pkg::OP_PUT,    8'h41, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_PUT,    8'h00, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_PUT,    8'hFF, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'd0,         11'd2);
    issue(tmcw_pkg::OP_PUT,    tmcw_pkg::NEWLINE_CODE, 7'd0, 5'd0, 8'd0, 11'd0);
    issue(tmcw_pkg::OP_GOTO,   8'h00, 7'd127, 5'd31, 8'd0,         11'd0);
    issue(tmcw_pkg::OP_PUT,    8'h78, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'd0,         11'd1919);
    issue(tmcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'd0,         11'd1999);
    issue(tmcw_pkg::OP_GOTO,   8'h00, 7'd5,   5'd24, 8'd0,         11'd0);
    issue(tmcw_pkg::OP_PUT,    tmcw_pkg::NEWLINE_CODE, 7'd0, 5'd0, 8'd0, 11'd0);
    issue(tmcw_pkg::OP_SCROLL, 8'h00, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_SCROLL, 8'h00, 7'd0,   5'd0,  8'd1,         11'd0);
    issue(tmcw_pkg::OP_SCROLL, 8'h00, 7'd0,   5'd0,  8'(ROWS),     11'd0);
    issue(tmcw_pkg::OP_GOTO,   8'h00, 7'd79,  5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_PUT,    8'h7E, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_SCROLL, 8'h00, 7'd0,   5'd0,  8'(ROWS + 1), 11'd0);
    issue(tmcw_pkg::OP_PUT,    8'h31, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_SCROLL, 8'h00, 7'd0,   5'd0,  8'd255,       11'd0);
    issue(tmcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'd0,         11'd2047);
    issue(3'(tmcw_pkg::OP_READ + 3'd1), 8'hFF, 7'd127, 5'd31, 8'd255, 11'd2047);
    issue(OP_HIGHEST,          8'h00, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_PUT,    8'h32, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_CLEAR,  8'h00, 7'd0,   5'd0,  8'd0,         11'd0);
    issue(tmcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'd0,         11'd0);

    phase_attr = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'($urandom), tmcw_pkg::ATTR_RESET};
    for (p = 0; p < PHASES; p++) begin
      write_attr(phase_attr[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        ch    = 8'($urandom_range(0, 255));
        col   = 7'($urandom_range(0, 127));
        row   = 5'($urandom_range(0, 31));
        lines = 8'($urandom_range(0, 255));
        addr  = 11'($urandom_range(0, 2047));
        pick  = $urandom_range(0, 99);
        if (pick < 60) begin
          op = tmcw_pkg::OP_PUT;
          if ($urandom_range(0, 99) < 7) ch = tmcw_pkg::NEWLINE_CODE;
        end else if (pick < 75) begin
          op = tmcw_pkg::OP_GOTO;
          if ($urandom_range(0, 9) < 6) row = 5'($urandom_range(ROWS - 3, ROWS - 1));
          if ($urandom_range(0, 9) < 8) col = 7'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 91) begin
          op = tmcw_pkg::OP_READ;
          if ($urandom_range(0, 9) < 7)
            addr = (last_pos > 11'd90) ? last_pos - 11'($urandom_range(0, 90))
                                       : 11'($urandom_range(0, 90));
        end else if (pick < 95) begin
          op   = tmcw_pkg::OP_SCROLL;
          pick = $urandom_range(0, 99);
          if (pick < 50) lines = 8'($urandom_range(1, 3));
          else if (pick < 65) lines = 8'd0;
          else if (pick < 75) lines = 8'(ROWS);
          else if (pick < 85) lines = 8'(ROWS + 1);
        end else if (pick < 96) begin
          op = tmcw_pkg::OP_CLEAR;
        end else begin
          op = 3'($urandom_range(tmcw_pkg::OP_READ + 1, OP_HIGHEST));
        end
        issue(op, ch, col, row, lines, addr);
        if (p != 2 && $urandom_range(0, 99) < 30) pause($urandom_range(1, 6));
        else if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

[text_mode_console_writer.f]
+incdir+sv
sv/tmcw_pkg.sv
sv/tmcw_seq.sv
sv/tmcw_dp.sv
sv/text_mode_console_writer.sv
sv/tmcw_checker.sv
tb/console_checker.sv
tb/tb_top.sv
